// ===== rtl/core/fspe_pkg.sv =====
// Shared constants, command codes and status type of the frame store paint engine.
`timescale 1ns / 1ps
`default_nettype none
package fspe_pkg;

  // Default screen size
  localparam int unsigned DefWidth  = 128;
  localparam int unsigned DefHeight = 160;

  // Field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned COLOUR_W = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_FILL_BG   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SCROLL_BG = 3'd1;
  localparam logic [REQ_W-1:0] REQ_COPY      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_PIX   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FILL_RECT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd5;

  // Commands from controller to datapath
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_LATCH,
    DP_FILL,
    DP_MOD,
    DP_SCROLL,
    DP_COPY,
    DP_RECT,
    DP_PIXEL,
    DP_READ,
    DP_LOAD_OUT
  } dp_cmd_e;

  // Status from datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic rect_last;
    logic rect_empty;
    logic mod_done;
    logic on_screen;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/frame_store_paint_engine_core.sv =====
// Top level of the frame store paint engine: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Two WIDTH x HEIGHT RGB565 stores (background and frame) in single-port-write
// RAMs, one pixel per cycle. After reset both stores are cleared by a pass over
// every pixel, during which no item is taken. Each item yields one result. The
// background fill and the copy to frame each sweep the whole screen, the
// rectangle fill writes the w*h pixels left after clipping, pixel set and read
// touch one pixel, and scroll reduces the row count modulo HEIGHT and then moves
// only a row offset (the rotation moves no pixel). Off-screen and unused
// requests do no pixel work and go straight to the result.
// A new item is taken while the previous result still waits on the output.
module frame_store_paint_engine_core #(
  parameter int unsigned WIDTH  = fspe_pkg::DefWidth,
  parameter int unsigned HEIGHT = fspe_pkg::DefHeight
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fspe_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  pos_x_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  pos_y_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  rect_w_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  rect_h_i,
  input  wire logic [fspe_pkg::COLOUR_W-1:0] colour_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  scroll_rows_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [fspe_pkg::COLOUR_W-1:0] read_data_o,
  output logic                               status_o
);

  fspe_pkg::dp_cmd_e    cmd;
  fspe_pkg::dp_status_t dp_stat;

  fspe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  fspe_datapath #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (dp_stat),
    .req_type_i    (req_type_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_w_i      (rect_w_i),
    .rect_h_i      (rect_h_i),
    .colour_i      (colour_i),
    .scroll_rows_i (scroll_rows_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .read_data_o   (read_data_o),
    .res_status_o  (status_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fspe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fspe_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fspe_datapath.sv =====
// Datapath: pixel stores, sweep and rectangle counters, scroll offset, result register.
`timescale 1ns / 1ps
`default_nettype none
module fspe_datapath #(
  parameter int unsigned WIDTH  = fspe_pkg::DefWidth,
  parameter int unsigned HEIGHT = fspe_pkg::DefHeight
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fspe_pkg::dp_cmd_e             cmd_i,
  output fspe_pkg::dp_status_t               stat_o,
  input  wire logic [fspe_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  pos_x_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  pos_y_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  rect_w_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  rect_h_i,
  input  wire logic [fspe_pkg::COLOUR_W-1:0] colour_i,
  input  wire logic [fspe_pkg::COORD_W-1:0]  scroll_rows_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [fspe_pkg::COLOUR_W-1:0] read_data_o,
  output logic                               res_status_o
);

  localparam int unsigned Pixels = WIDTH * HEIGHT;
  localparam int unsigned AddrW  = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam int unsigned CW     = fspe_pkg::COORD_W;
  localparam int unsigned PW     = fspe_pkg::COLOUR_W;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Pixels - 1);
  localparam logic [CW:0]      WidthX   = (CW + 1)'(WIDTH);
  localparam logic [CW:0]      HeightX  = (CW + 1)'(HEIGHT);

  logic [fspe_pkg::REQ_W-1:0] op_q;
  logic [PW-1:0]    colour_q;
  logic [CW-1:0]    rows_q;
  logic [AddrW-1:0] base_q;
  logic [CW-1:0]    w_eff_q, h_eff_q;
  logic [CW-1:0]    col_q, row_q;
  logic [AddrW-1:0] idx_q, bg_ptr_q, pend_addr_q;
  logic [CW-1:0]    off_q;
  logic             pend_q, onscr_q;
  logic             out_valid_q, out_stat_q;
  logic [PW-1:0]    out_data_q;

  logic             on_screen;
  logic [CW:0]      x_room, y_room;
  logic [CW-1:0]    w_clip, h_clip;
  logic [AddrW-1:0] pix_addr;

  logic             fr_we, fr_re, bg_we, bg_re;
  logic [AddrW-1:0] fr_waddr, bg_waddr;
  logic [PW-1:0]    fr_wdata, bg_wdata, fr_rdata, bg_rdata;

  // Check origin and clip the rectangle against the screen edges
  assign on_screen = ({1'b0, pos_x_i} < WidthX) && ({1'b0, pos_y_i} < HeightX);
  assign x_room    = WidthX - {1'b0, pos_x_i};
  assign y_room    = HeightX - {1'b0, pos_y_i};
  assign w_clip    = ({1'b0, rect_w_i} > x_room) ? x_room[CW-1:0] : rect_w_i;
  assign h_clip    = ({1'b0, rect_h_i} > y_room) ? y_room[CW-1:0] : rect_h_i;
  assign pix_addr  = AddrW'(AddrW'(pos_y_i) * AddrW'(WIDTH)) + AddrW'(pos_x_i);

  // Status back to the controller
  assign stat_o.sweep_last = (idx_q == LastAddr);
  assign stat_o.rect_last  = (col_q == w_eff_q - CW'(1)) && (row_q == h_eff_q - CW'(1));
  assign stat_o.rect_empty = (w_eff_q == '0) || (h_eff_q == '0);
  assign stat_o.mod_done   = ({1'b0, rows_q} < HeightX);
  assign stat_o.on_screen  = on_screen;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Frame store port selection
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = base_q;
    fr_wdata = colour_q;
    if (pend_q) begin
      fr_we    = 1'b1;
      fr_waddr = pend_addr_q;
      fr_wdata = bg_rdata;
    end else if (cmd_i == fspe_pkg::DP_CLEAR) begin
      fr_we    = 1'b1;
      fr_waddr = idx_q;
      fr_wdata = '0;
    end else if (cmd_i == fspe_pkg::DP_RECT) begin
      fr_we    = 1'b1;
      fr_waddr = base_q + AddrW'(col_q);
    end else if (cmd_i == fspe_pkg::DP_PIXEL) begin
      fr_we    = 1'b1;
    end
  end
  assign fr_re = (cmd_i == fspe_pkg::DP_READ);

  // Background store port selection
  assign bg_we    = (cmd_i == fspe_pkg::DP_CLEAR) || (cmd_i == fspe_pkg::DP_FILL);
  assign bg_waddr = idx_q;
  assign bg_wdata = (cmd_i == fspe_pkg::DP_FILL) ? colour_q : '0;
  assign bg_re    = (cmd_i == fspe_pkg::DP_COPY);

  fspe_ram #(.DATA_W(PW), .DEPTH(Pixels)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (base_q),
    .rdata_o (fr_rdata)
  );

  fspe_ram #(.DATA_W(PW), .DEPTH(Pixels)) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (bg_we),
    .waddr_i (bg_waddr),
    .wdata_i (bg_wdata),
    .re_i    (bg_re),
    .raddr_i (bg_ptr_q),
    .rdata_o (bg_rdata)
  );

  // Execute datapath commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= '0;
      colour_q    <= '0;
      rows_q      <= '0;
      base_q      <= '0;
      w_eff_q     <= '0;
      h_eff_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      bg_ptr_q    <= '0;
      pend_addr_q <= '0;
      off_q       <= '0;
      pend_q      <= 1'b0;
      onscr_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_stat_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      pend_q <= (cmd_i == fspe_pkg::DP_COPY);
      if (cmd_i == fspe_pkg::DP_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        fspe_pkg::DP_LATCH: begin
          op_q     <= req_type_i;
          colour_q <= colour_i;
          rows_q   <= scroll_rows_i;
          base_q   <= pix_addr;
          w_eff_q  <= w_clip;
          h_eff_q  <= h_clip;
          col_q    <= '0;
          row_q    <= '0;
          idx_q    <= '0;
          bg_ptr_q <= AddrW'(AddrW'(off_q) * AddrW'(WIDTH));
          onscr_q  <= on_screen;
        end
        fspe_pkg::DP_CLEAR, fspe_pkg::DP_FILL: begin
          idx_q <= (idx_q == LastAddr) ? '0 : idx_q + AddrW'(1);
        end
        fspe_pkg::DP_COPY: begin
          pend_addr_q <= idx_q;
          idx_q       <= (idx_q == LastAddr) ? '0 : idx_q + AddrW'(1);
          bg_ptr_q    <= (bg_ptr_q == LastAddr) ? '0 : bg_ptr_q + AddrW'(1);
        end
        fspe_pkg::DP_MOD: begin
          rows_q <= CW'({1'b0, rows_q} - HeightX);
        end
        fspe_pkg::DP_SCROLL: begin
          if (off_q >= rows_q) begin
            off_q <= off_q - rows_q;
          end else begin
            off_q <= CW'({1'b0, off_q} + HeightX - {1'b0, rows_q});
          end
        end
        fspe_pkg::DP_RECT: begin
          if (col_q == w_eff_q - CW'(1)) begin
            col_q  <= '0;
            row_q  <= row_q + CW'(1);
            base_q <= base_q + AddrW'(WIDTH);
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        fspe_pkg::DP_LOAD_OUT: begin
          out_data_q  <= (op_q == fspe_pkg::REQ_READ && onscr_q) ? fr_rdata : '0;
          out_stat_q  <= !onscr_q && (op_q == fspe_pkg::REQ_SET_PIX ||
                                      op_q == fspe_pkg::REQ_FILL_RECT ||
                                      op_q == fspe_pkg::REQ_READ);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign res_status_o = out_stat_q;

  // Scroll offset always names a real row
  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, off_q} < HeightX)
    else $error("scroll offset out of range");

  // A pending frame write only follows a copy read
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(cmd_i == fspe_pkg::DP_COPY))
    else $error("frame write pending without copy read");

  // Rectangle row counter never passes the clipped height
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_eff_q)
    else $error("rectangle row beyond clipped height");

endmodule
`default_nettype wire

// ===== rtl/core/fspe_ctrl.sv =====
// Controller: sequences clearing, sweeps, rectangle fill and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module fspe_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [fspe_pkg::REQ_W-1:0] req_type_i,
  input  wire fspe_pkg::dp_status_t       stat_i,
  output logic                            in_ready_o,
  output fspe_pkg::dp_cmd_e               cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_MOD,
    ST_COPY,
    ST_DRAIN,
    ST_RECT,
    ST_PIXEL,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // Issue the command for the current state
  always_comb begin
    cmd_o = fspe_pkg::DP_NONE;
    unique case (state_q)
      ST_CLEAR:  cmd_o = fspe_pkg::DP_CLEAR;
      ST_IDLE:   if (in_valid_i) cmd_o = fspe_pkg::DP_LATCH;
      ST_FILL:   cmd_o = fspe_pkg::DP_FILL;
      ST_MOD:    cmd_o = stat_i.mod_done ? fspe_pkg::DP_SCROLL : fspe_pkg::DP_MOD;
      ST_COPY:   cmd_o = fspe_pkg::DP_COPY;
      ST_DRAIN:  cmd_o = fspe_pkg::DP_NONE;
      ST_RECT:   if (!stat_i.rect_empty) cmd_o = fspe_pkg::DP_RECT;
      ST_PIXEL:  cmd_o = fspe_pkg::DP_PIXEL;
      ST_READ:   cmd_o = fspe_pkg::DP_READ;
      ST_FINISH: if (stat_i.out_free) cmd_o = fspe_pkg::DP_LOAD_OUT;
      default:   cmd_o = fspe_pkg::DP_NONE;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR: if (stat_i.sweep_last) state_q <= ST_IDLE;
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (req_type_i)
              fspe_pkg::REQ_FILL_BG:   state_q <= ST_FILL;
              fspe_pkg::REQ_SCROLL_BG: state_q <= ST_MOD;
              fspe_pkg::REQ_COPY:      state_q <= ST_COPY;
              fspe_pkg::REQ_SET_PIX:   state_q <= stat_i.on_screen ? ST_PIXEL : ST_FINISH;
              fspe_pkg::REQ_FILL_RECT: state_q <= stat_i.on_screen ? ST_RECT : ST_FINISH;
              fspe_pkg::REQ_READ:      state_q <= stat_i.on_screen ? ST_READ : ST_FINISH;
              default:                 state_q <= ST_FINISH;
            endcase
          end
        end
        ST_FILL:  if (stat_i.sweep_last) state_q <= ST_FINISH;
        ST_MOD:   if (stat_i.mod_done) state_q <= ST_FINISH;
        ST_COPY:  if (stat_i.sweep_last) state_q <= ST_DRAIN;
        ST_DRAIN: state_q <= ST_FINISH;
        ST_RECT:  if (stat_i.rect_empty || stat_i.rect_last) state_q <= ST_FINISH;
        ST_PIXEL: state_q <= ST_FINISH;
        ST_READ:  state_q <= ST_FINISH;
        ST_FINISH: if (stat_i.out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Load the result only once all work of the item is done
  a_load_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == fspe_pkg::DP_LOAD_OUT) |=> (state_q == ST_IDLE))
    else $error("result loaded outside finish");

  // A request is latched only when one is taken in
  a_latch_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == fspe_pkg::DP_LATCH) |-> (in_ready_o && in_valid_i))
    else $error("latch without accepted item");

  // The drain cycle always follows the last copy read
  a_drain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> $past(cmd_o == fspe_pkg::DP_COPY))
    else $error("drain without copy");

endmodule
`default_nettype wire

// ===== tb/tb_frame_store_paint_engine_core.sv =====
// Self-checking testbench for the frame store paint engine core.
`timescale 1ns / 1ps
module tb_frame_store_paint_engine_core;

  typedef logic [fspe_pkg::REQ_W-1:0]    op_t;
  typedef logic [fspe_pkg::COORD_W-1:0]  coord_t;
  typedef logic [fspe_pkg::COLOUR_W-1:0] colour_t;

  localparam int unsigned SCR_W = fspe_pkg::DefWidth;
  localparam int unsigned SCR_H = fspe_pkg::DefHeight;
  localparam int unsigned PIXELS = SCR_W * SCR_H;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam op_t REQ_SPARE_A = 3'd6;
  localparam op_t REQ_SPARE_B = 3'd7;

  typedef struct {
    op_t     op;
    coord_t  x;
    coord_t  y;
    coord_t  w;
    coord_t  h;
    colour_t colour;
    coord_t  rows;
    bit      drain_first;
  } paint_req_t;

  typedef struct {
    colour_t data;
    logic    status;
  } paint_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  op_t     req_type_i = '0;
  coord_t  pos_x_i = '0;
  coord_t  pos_y_i = '0;
  coord_t  rect_w_i = '0;
  coord_t  rect_h_i = '0;
  colour_t colour_i = '0;
  coord_t  scroll_rows_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  colour_t read_data_o;
  logic status_o;

  frame_store_paint_engine_core uut (.*);

  always #4 clk_i = ~clk_i;

  // Shadow copies of both pixel stores
  colour_t frame_px[PIXELS];
  colour_t bg_px[PIXELS];
  colour_t rot_px[PIXELS];

  paint_req_t pending_q[$];
  paint_res_t result_q[$];
  paint_req_t cur_req;
  int unsigned accepted_cnt = 0;
  int unsigned total_items = 1 << 30;
  int unsigned op_seen[8];
  int unsigned error_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit held_once = 0;

  // Apply one request to the shadow stores and work out its result
  function automatic paint_res_t paint_predict(paint_req_t r);
    paint_res_t res;
    bit on_scr;
    int unsigned n, cw, ch;
    res.data = '0;
    res.status = 1'b0;
    on_scr = (r.x < SCR_W) && (r.y < SCR_H);
    case (r.op)
      fspe_pkg::REQ_FILL_BG: begin
        foreach (bg_px[i]) bg_px[i] = r.colour;
      end
      fspe_pkg::REQ_SCROLL_BG: begin
        n = r.rows % SCR_H;
        if (n != 0) begin
          for (int unsigned row = 0; row < SCR_H; row++)
            for (int unsigned col = 0; col < SCR_W; col++)
              rot_px[row*SCR_W+col] = bg_px[((row+SCR_H-n)%SCR_H)*SCR_W+col];
          bg_px = rot_px;
        end
      end
      fspe_pkg::REQ_COPY: frame_px = bg_px;
      fspe_pkg::REQ_SET_PIX: begin
        if (on_scr) frame_px[r.y*SCR_W+r.x] = r.colour;
        else res.status = 1'b1;
      end
      fspe_pkg::REQ_FILL_RECT: begin
        if (on_scr) begin
          cw = (r.w > SCR_W - r.x) ? SCR_W - r.x : r.w;
          ch = (r.h > SCR_H - r.y) ? SCR_H - r.y : r.h;
          for (int unsigned j = 0; j < ch; j++)
            for (int unsigned i = 0; i < cw; i++)
              frame_px[(r.y+j)*SCR_W + r.x + i] = r.colour;
        end else begin
          res.status = 1'b1;
        end
      end
      fspe_pkg::REQ_READ: begin
        if (on_scr) res.data = frame_px[r.y*SCR_W+r.x];
        else res.status = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic paint_req_t mk_req(op_t op, int x, int y, int w, int h,
                                        int colour, int rows);
    paint_req_t r;
    r.op = op;
    r.x = coord_t'(x);
    r.y = coord_t'(y);
    r.w = coord_t'(w);
    r.h = coord_t'(h);
    r.colour = colour_t'(colour);
    r.rows = coord_t'(rows);
    r.drain_first = 0;
    return r;
  endfunction

  // Append one item to the queue of pending items
  task automatic add_item(paint_req_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  // Driver: present queued items, record each accepted item
  always @(posedge clk_i) begin
    logic nv;
    nv = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        result_q.insert(result_q.size(), paint_predict(cur_req));
        op_seen[cur_req.op]++;
        accepted_cnt++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (accepted_cnt < total_items - 15 && $urandom_range(0, 5) == 0) begin
          gap_cnt = $urandom_range(1, 7) - 1;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && result_q.size() != 0)) begin
          cur_req = pending_q.pop_front();
          nv = 1'b1;
          req_type_i <= cur_req.op;
          pos_x_i <= cur_req.x;
          pos_y_i <= cur_req.y;
          rect_w_i <= cur_req.w;
          rect_h_i <= cur_req.h;
          colour_i <= cur_req.colour;
          scroll_rows_i <= cur_req.rows;
        end
      end
    end
    in_valid_i <= nv;
  end

  // Monitor: stall the output side and check each result item
  always @(posedge clk_i) begin
    logic nr;
    paint_res_t exp_res;
    nr = 1'b1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked_cnt++;
        if (result_q.size() == 0) begin
          $error("result item with nothing expected: read_data %h status %b",
                 read_data_o, status_o);
          error_cnt++;
        end else begin
          exp_res = result_q.pop_front();
          if (read_data_o !== exp_res.data) begin
            $error("read_data expected %h actual %h", exp_res.data, read_data_o);
            error_cnt++;
          end
          if (status_o !== exp_res.status) begin
            $error("status expected %b actual %b", exp_res.status, status_o);
            error_cnt++;
          end
        end
      end
      // Long hold-off once, longer than a whole-screen pass, so the block backs up
      if (hold_cnt > 0) begin
        hold_cnt--;
        nr = 1'b0;
      end else if (!held_once && accepted_cnt >= 35) begin
        held_once = 1;
        hold_cnt = 30000;
        nr = 1'b0;
      end else if (accepted_cnt >= total_items - 15) begin
        nr = 1'b1;
      end else if (idle_cnt > 0) begin
        idle_cnt--;
        nr = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        idle_cnt = $urandom_range(1, 7) - 1;
        nr = 1'b0;
      end
    end else begin
      nr = 1'b0;
    end
    out_ready_i <= nr;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    paint_req_t r;
    int unsigned pick, big_ops;
    foreach (frame_px[i]) begin
      frame_px[i] = '0;
      bg_px[i] = '0;
    end
    foreach (op_seen[i]) op_seen[i] = 0;
    big_ops = 0;

    // Directed: extremes, every operation but copy, each corner case
    add_item(mk_req(fspe_pkg::REQ_READ, 127, 159, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_BG, 255, 255, 255, 255, 16'hFFFF, 255));
    add_item(mk_req(fspe_pkg::REQ_SET_PIX, 0, 0, 0, 0, 16'h0000, 0));
    add_item(mk_req(fspe_pkg::REQ_SET_PIX, 127, 159, 0, 0, 16'hA5A5, 0));
    add_item(mk_req(fspe_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_READ, 127, 159, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_SET_PIX, 128, 5, 0, 0, 16'h1111, 0));
    add_item(mk_req(fspe_pkg::REQ_SET_PIX, 5, 160, 0, 0, 16'h2222, 0));
    add_item(mk_req(fspe_pkg::REQ_READ, 255, 255, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_RECT, 200, 10, 4, 4, 16'h3333, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_RECT, 10, 10, 0, 5, 16'h4444, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_RECT, 10, 10, 5, 0, 16'h4444, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_RECT, 120, 150, 255, 255, 16'h1234, 0));
    add_item(mk_req(fspe_pkg::REQ_READ, 127, 159, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_READ, 119, 149, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_RECT, 0, 0, 1, 1, 16'h8001, 0));
    add_item(mk_req(fspe_pkg::REQ_SCROLL_BG, 0, 0, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_SET_PIX, 3, 0, 0, 0, 0, 0));
    add_item(mk_req(fspe_pkg::REQ_FILL_BG, 0, 0, 0, 0, 16'h0000, 0));
    add_item(mk_req(fspe_pkg::REQ_SCROLL_BG, 0, 0, 0, 0, 0, 160));
    add_item(mk_req(fspe_pkg::REQ_SCROLL_BG, 0, 0, 0, 0, 0, 255));
    add_item(mk_req(REQ_SPARE_A, 1, 2, 3, 4, 16'hFFFF, 5));
    add_item(mk_req(REQ_SPARE_B, 255, 255, 255, 255, 16'hFFFF, 255));
    big_ops = 3;

    // Random: mostly small pixel work, rare whole-screen operations
    for (int k = 0; k < 80; k++) begin
      pick = $urandom_range(0, 99);
      r = mk_req(fspe_pkg::REQ_READ, $urandom_range(0, SCR_W-1), $urandom_range(0, SCR_H-1),
                 $urandom_range(0, 6), $urandom_range(0, 6), $urandom, $urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) r.x = coord_t'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) r.y = coord_t'($urandom_range(0, 255));
      if (pick < 4 && big_ops < 16) begin
        r.op = fspe_pkg::REQ_FILL_BG; big_ops++;
      end else if (pick < 9 && big_ops < 16) begin
        r.op = fspe_pkg::REQ_COPY; big_ops++;
      end else if (pick < 18) r.op = fspe_pkg::REQ_SCROLL_BG;
      else if (pick < 45) r.op = fspe_pkg::REQ_SET_PIX;
      else if (pick < 62) begin
        r.op = fspe_pkg::REQ_FILL_RECT;
        if ($urandom_range(0, 9) == 0) begin
          r.w = coord_t'($urandom_range(0, 255));
          r.h = coord_t'($urandom_range(0, 40));
        end
      end else if (pick < 96) r.op = fspe_pkg::REQ_READ;
      else r.op = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
      if (k == 60) r.drain_first = 1;
      add_item(r);
    end
    total_items = pending_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == total_items && result_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("items %0d, results checked %0d", accepted_cnt, checked_cnt);
    $display("fill %0d scroll %0d copy %0d pixel %0d rect %0d read %0d spare %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6] + op_seen[7]);
    if (error_cnt == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
